/* rtl/modular_exponentiation_core_macros.svh */
// ----------------------------------------------------------------------------
// modexp assertion macros
// shared assertion forms for the modular exponentiation core
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// property that holds at every clock edge outside reset
`define MX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the next clock edge
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants, types and codes of the modular exponentiation core
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned ModWidthDef = 62;
  localparam int unsigned BaseWidth   = 62;
  localparam int unsigned ExpWidth    = 63;
  localparam int unsigned OutWidth    = 62;

  // operation codes for the shared modular multiplier
  typedef enum logic [1:0] {
    OP_REDUCE = 2'b00,
    OP_MUL    = 2'b01,
    OP_SQR    = 2'b10
  } mul_op_e;

  // handshake between the sequencer and the multiplier
  typedef struct packed {
    logic    start;
    mul_op_e op;
  } mul_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

/* rtl/mexp_mulmod.sv */
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial shift-and-add modular multiplier, one multiplier bit a cycle
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::ModWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mexp_pkg::mul_ctrl_t              ctrl_i,
  input  logic [MOD_WIDTH-1:0]             a_i,
  input  logic [mexp_pkg::BaseWidth-1:0]   b_i,
  input  logic [MOD_WIDTH-1:0]             m_i,
  output logic [MOD_WIDTH-1:0]             p_o,
  output mexp_pkg::mul_stat_t              stat_o
);

  localparam int unsigned BWidth = mexp_pkg::BaseWidth;
  localparam int unsigned CntW   = $clog2(BWidth + 1);

  logic [MOD_WIDTH-1:0] acc_q, acc_d, a_q, a_d;
  logic [BWidth-1:0]    b_q, b_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [MOD_WIDTH:0]   dbl, dbl_r, sum;
  logic [MOD_WIDTH-1:0] acc2;

  always_comb begin
    // acc = 2*acc mod m, then + a if bit set
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum   = dbl_r + (b_q[BWidth-1] ? {1'b0, a_q} : '0);
    if (sum >= {1'b0, m_i}) begin
      acc2 = MOD_WIDTH'(sum - {1'b0, m_i});
    end else begin
      acc2 = MOD_WIDTH'(sum);
    end
  end

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      acc_d  = '0;
      cnt_d  = CntW'(BWidth);
      case (ctrl_i.op)
        // reduction: 1 * base mod m over all base bits
        mexp_pkg::OP_REDUCE: begin
          a_d = MOD_WIDTH'(1);
          b_d = b_i;
        end
        mexp_pkg::OP_MUL: begin
          a_d = a_i;
          b_d = b_i;
        end
        mexp_pkg::OP_SQR: begin
          a_d = MOD_WIDTH'(b_i);
          b_d = b_i;
        end
        default: begin
          a_d = a_i;
          b_d = b_i;
        end
      endcase
    end else if (busy_q) begin
      acc_d = acc2;
      b_d   = b_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign p_o         = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* rtl/mexp_seq.sv */
// ----------------------------------------------------------------------------
// mexp_seq
// right-to-left square-and-multiply sequencer around the shared multiplier
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module mexp_seq #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::ModWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mexp_pkg::BaseWidth-1:0]    base_i,
  input  logic [mexp_pkg::ExpWidth-1:0]     exp_i,
  input  logic [MOD_WIDTH-1:0]              mod_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mexp_pkg::OutWidth-1:0]     result_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_MUL    = 6'b000100,
    S_SQR    = 6'b001000,
    S_WAIT   = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e                         state_q, state_d;
  mexp_pkg::mul_op_e              op_q, op_d;
  logic [MOD_WIDTH-1:0]           acc_q, acc_d;
  logic [mexp_pkg::BaseWidth-1:0] base_q, base_d;
  logic [mexp_pkg::ExpWidth-1:0]  exp_q, exp_d;
  logic [mexp_pkg::OutWidth-1:0]  res_q, res_d;
  logic                           small_mod;
  mexp_pkg::mul_ctrl_t            mctrl;
  mexp_pkg::mul_stat_t            mstat;
  logic [MOD_WIDTH-1:0]           mul_a, mul_p;

  assign small_mod = (mod_i < MOD_WIDTH'(2));

  mexp_mulmod #(.MOD_WIDTH(MOD_WIDTH)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctrl),
    .a_i    (mul_a),
    .b_i    (base_q),
    .m_i    (mod_i),
    .p_o    (mul_p),
    .stat_o (mstat)
  );

  always_comb begin
    mctrl.start = 1'b0;
    mctrl.op    = mexp_pkg::OP_MUL;
    mul_a       = acc_q;
    case (state_q)
      S_REDUCE: begin
        mctrl.start = 1'b1;
        mctrl.op    = mexp_pkg::OP_REDUCE;
      end
      S_MUL: begin
        mctrl.start = 1'b1;
        mctrl.op    = mexp_pkg::OP_MUL;
      end
      S_SQR: begin
        mctrl.start = 1'b1;
        mctrl.op    = mexp_pkg::OP_SQR;
      end
      default: begin
        mctrl.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    base_d  = base_q;
    exp_d   = exp_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          exp_d  = exp_i;
          acc_d  = MOD_WIDTH'(1);
          base_d = base_i;
          if (small_mod) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        op_d    = mexp_pkg::OP_REDUCE;
        state_d = S_WAIT;
      end
      S_MUL: begin
        op_d    = mexp_pkg::OP_MUL;
        state_d = S_WAIT;
      end
      S_SQR: begin
        op_d    = mexp_pkg::OP_SQR;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mstat.done) begin
          case (op_q)
            mexp_pkg::OP_REDUCE: base_d = mexp_pkg::BaseWidth'(mul_p);
            mexp_pkg::OP_MUL:    acc_d  = mul_p;
            mexp_pkg::OP_SQR: begin
              base_d = mexp_pkg::BaseWidth'(mul_p);
              exp_d  = exp_q >> 1;
            end
            default: acc_d = acc_q;
          endcase
          // after a multiply the square follows; otherwise finish on a zero exponent or test its low bit
          if (op_q == mexp_pkg::OP_MUL) begin
            state_d = S_SQR;
          end else begin
            if (op_q == mexp_pkg::OP_REDUCE) begin
              exp_d = exp_q;
            end
            if (exp_d == '0) begin
              res_d   = mexp_pkg::OutWidth'(acc_d);
              state_d = S_OUT;
            end else if (exp_d[0]) begin
              state_d = S_MUL;
            end else begin
              state_d = S_SQR;
            end
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= mexp_pkg::OP_MUL;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign result_o    = res_q;

  `MX_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `MX_ASSERT(a_no_overlap, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while result held")
  `MX_ASSERT_NEXT(a_wait_busy, clk_i, rst_ni, state_q == S_MUL || state_q == S_SQR,
    mstat.busy, "multiplier not started")
  `MX_ASSERT(a_res_range, clk_i, rst_ni,
    !out_valid_o || small_mod || (MOD_WIDTH'(res_q) < mod_i), "result not reduced")

endmodule

/* rtl/modular_exponentiation_core.sv */
// per input item: one reduction of the base, then for each exponent bit up to
// the top set bit a multiply where that bit is set, followed by a square
// exponent zero gives 1 after the reduction alone; a modulus below 2 answers 0 without the multiplier
// one item at a time: ready again the cycle after the result item is taken
// reset: asynchronous active low, modulus returns to 2, sequencer to idle
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base to the exponent modulo a configured modulus, right-to-left binary method
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int unsigned MOD_WIDTH = mexp_pkg::ModWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,     // [61:0] modulus
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,    // [61:0] base_value, [124:62] exponent
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata     // [61:0] power_result
);

  logic [MOD_WIDTH-1:0]           mod_q;
  logic [mexp_pkg::OutWidth-1:0]  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_WIDTH'(2);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i[MOD_WIDTH-1:0];
    end
  end

  mexp_seq #(.MOD_WIDTH(MOD_WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .base_i      (s_axis_tdata[61:0]),
    .exp_i       (s_axis_tdata[124:62]),
    .mod_i       (mod_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {2'b00, result};

endmodule
